/* hw/rtl/dtrf_pkg.sv */
// shared types and constants for the device table replay filter
package dtrf_pkg;

   localparam int BOOT_W = 32;
   localparam int SEQ_W  = 32;
   localparam int TIME_W = 64;

   typedef enum logic [1:0] {
      ACT_REGISTER = 2'd0,
      ACT_RELEASE  = 2'd1,
      ACT_MESSAGE  = 2'd2,
      ACT_AVAIL    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      STS_OK        = 3'd0,
      STS_NOT_FOUND = 3'd1,
      STS_INVALID   = 3'd2,
      STS_REPLAY    = 3'd3,
      STS_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'd0,
      FSM_SCAN = 2'd1,
      FSM_READ = 2'd2,
      FSM_EXEC = 2'd3
   } fsm_type;

   // per-slot record kept in the data memory
   typedef struct packed {
      logic [BOOT_W-1:0] boot;
      logic [SEQ_W-1:0]  newest;
      logic [TIME_W-1:0] last_seen;
      logic              online;
   } record_type;

   // lookup outcome handed from the scanner to the sequencer
   typedef struct packed {
      logic done;
      logic hit;
      logic free_found;
   } scan_result_type;

endpackage

/* hw/rtl/dtrf_ram.sv */
// generic single-port-write, registered-read memory
module dtrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/dtrf_lookup.sv */
// key scanner: one comparator walks the slots, also finds the lowest free slot
module dtrf_lookup #(
   parameter int DEVICE_SLOTS = 16,
   parameter int KEY_W        = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [KEY_W-1:0]                       key,
   input  logic [DEVICE_SLOTS-1:0]                used,
   output logic [(DEVICE_SLOTS > 1 ? $clog2(DEVICE_SLOTS) : 1)-1:0] key_rd_addr,
   input  logic [KEY_W-1:0]                       key_rd_data,
   output dtrf_pkg::scan_result_type              result,
   output logic [(DEVICE_SLOTS > 1 ? $clog2(DEVICE_SLOTS) : 1)-1:0] hit_idx,
   output logic [(DEVICE_SLOTS > 1 ? $clog2(DEVICE_SLOTS) : 1)-1:0] free_idx
);

   localparam int IDX_W = DEVICE_SLOTS > 1 ? $clog2(DEVICE_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEVICE_SLOTS - 1);

   logic             active_ff, active_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             done_ff, done_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             match;

   assign match = pend_ff && used[cmp_idx_ff] && (key_rd_data == key);

   always_comb begin
      active_in     = active_ff;
      pend_in       = pend_ff;
      addr_in       = addr_ff;
      cmp_idx_in    = cmp_idx_ff;
      done_in       = done_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      if (start) begin
         active_in     = 1'b1;
         pend_in       = 1'b0;
         addr_in       = '0;
         done_in       = 1'b0;
         hit_in        = 1'b0;
         free_found_in = 1'b0;
      end else if (active_ff) begin
         // lowest unused slot, noted while walking
         if (pend_ff && !used[cmp_idx_ff] && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = cmp_idx_ff;
         end
         if (pend_ff && (match || cmp_idx_ff == LAST_IDX)) begin
            active_in  = 1'b0;
            pend_in    = 1'b0;
            done_in    = 1'b1;
            hit_in     = match;
            hit_idx_in = cmp_idx_ff;
         end else begin
            pend_in    = 1'b1;
            cmp_idx_in = addr_ff;
            addr_in    = (addr_ff == LAST_IDX) ? addr_ff : addr_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         pend_ff       <= 1'b0;
         done_ff       <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         active_ff     <= active_in;
         pend_ff       <= pend_in;
         done_ff       <= done_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
      end
      addr_ff     <= addr_in;
      cmp_idx_ff  <= cmp_idx_in;
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
   end

   assign key_rd_addr       = addr_ff;
   assign result.done       = done_ff;
   assign result.hit        = hit_ff;
   assign result.free_found = free_found_ff;
   assign hit_idx           = hit_idx_ff;
   assign free_idx          = free_idx_ff;

endmodule

/* hw/rtl/device_table_replay_filter_unit.sv */
// top level: device slot table with per-device replay filter
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+------------------------------------------
//   req_    | in  | req_valid / req_stall  | action, node_key, boot_id, sequence_req,
//           |     |                        | time_ms, online
//   rsp_    | out | rsp_valid / rsp_stall  | status, slot, device_total
//
// the key walk stops at the first hit, else at the last slot; a beat holds the block from
// acceptance through scan, record read and exec, and the next beat is taken once it is idle
// the walk compares the slots in turn behind a registered key read, then record read and action
// req_stall is high from acceptance until the action is applied, longer while a result is
// held by rsp_stall; the result waits in an output register, so the next request is taken
// while it is unread; synchronous active-high reset empties the table (valid bit per slot)
module device_table_replay_filter_unit #(
   parameter int DEVICE_SLOTS = 16,
   parameter int KEY_BYTES    = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [63:0] req_node_key,
   input  logic [31:0] req_boot_id,
   input  logic [31:0] req_sequence_req,
   input  logic [63:0] req_time_ms,
   input  logic        req_online,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_slot,
   output logic [4:0]  rsp_device_total
);

   localparam int IDX_W = DEVICE_SLOTS > 1 ? $clog2(DEVICE_SLOTS) : 1;
   localparam int CNT_W = $clog2(DEVICE_SLOTS + 1);
   localparam int KEY_W = 8 * KEY_BYTES;
   localparam int REC_W = $bits(dtrf_pkg::record_type);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   // sequencer
   dtrf_pkg::fsm_type fsm_ff, fsm_in;

   // latched request beat
   dtrf_pkg::action_type act_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [31:0]          boot_ff;
   logic [31:0]          seq_ff;
   logic [63:0]          time_ff;
   logic                 online_ff;

   // table state
   logic [DEVICE_SLOTS-1:0] used_ff, used_in;
   logic [CNT_W-1:0]        total_ff, total_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   dtrf_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [3:0]            rsp_slot_ff, rsp_slot_in;
   logic [4:0]            rsp_total_ff, rsp_total_in;

   // lookup and memories
   logic                      req_take;
   logic                      scan_start;
   dtrf_pkg::scan_result_type scan_res;
   logic [IDX_W-1:0]          hit_idx;
   logic [IDX_W-1:0]          free_idx;
   logic [IDX_W-1:0]          key_rd_addr;
   logic [KEY_W-1:0]          key_rd_data;
   logic                      key_we;
   logic                      rec_we;
   dtrf_pkg::record_type      rec_wdata;
   logic [REC_W-1:0]          rec_rd_bits;
   dtrf_pkg::record_type      rec_rd;
   logic [IDX_W-1:0]          wr_idx;
   logic                      exec_fire;

   // exec decisions
   dtrf_pkg::status_type      status_sel;
   logic                      slot_none;
   logic                      used_set;
   logic                      used_clr;
   logic [31:0]               seq_diff;
   logic                      not_newer;
   logic [IDX_W+3:0]          slot_wide;
   logic [CNT_W+4:0]          total_wide;

   assign req_take  = req_valid && !req_stall;
   assign exec_fire = (fsm_ff == dtrf_pkg::FSM_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign wr_idx    = scan_res.hit ? hit_idx : free_idx;
   assign rec_rd    = dtrf_pkg::record_type'(rec_rd_bits);

   // next state
   always_comb begin
      fsm_in = fsm_ff;
      unique case (fsm_ff)
         dtrf_pkg::FSM_IDLE: begin
            if (req_take) begin
               fsm_in = dtrf_pkg::FSM_SCAN;
            end
         end
         dtrf_pkg::FSM_SCAN: begin
            if (scan_res.done) begin
               fsm_in = dtrf_pkg::FSM_READ;
            end
         end
         dtrf_pkg::FSM_READ: begin
            fsm_in = dtrf_pkg::FSM_EXEC;
         end
         dtrf_pkg::FSM_EXEC: begin
            if (exec_fire) begin
               fsm_in = dtrf_pkg::FSM_IDLE;
            end
         end
         default: begin
            fsm_in = dtrf_pkg::FSM_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall  = (fsm_ff != dtrf_pkg::FSM_IDLE);
      scan_start = (fsm_ff == dtrf_pkg::FSM_IDLE) && req_valid;
   end

   // replay check: sequence must be strictly newer in wrap-around order
   assign seq_diff  = seq_ff - rec_rd.newest;
   assign not_newer = (seq_diff == 32'd0) || seq_diff[31];

   // action decode, applied in the exec cycle
   always_comb begin
      status_sel = dtrf_pkg::STS_OK;
      slot_none  = 1'b0;
      used_set   = 1'b0;
      used_clr   = 1'b0;
      key_we     = 1'b0;
      rec_we     = 1'b0;
      rec_wdata  = '0;
      if (act_ff == dtrf_pkg::ACT_REGISTER) begin
         if (!scan_res.hit) begin
            if (scan_res.free_found) begin
               // fresh slot: key written, record cleared
               key_we   = 1'b1;
               rec_we   = 1'b1;
               used_set = 1'b1;
            end else begin
               status_sel = dtrf_pkg::STS_FULL;
               slot_none  = 1'b1;
            end
         end
      end else if (!scan_res.hit) begin
         status_sel = dtrf_pkg::STS_NOT_FOUND;
         slot_none  = 1'b1;
      end else begin
         unique case (act_ff)
            dtrf_pkg::ACT_RELEASE: begin
               used_clr = 1'b1;
               rec_we   = 1'b1;
            end
            dtrf_pkg::ACT_MESSAGE: begin
               if (boot_ff == 32'd0 || seq_ff == 32'd0) begin
                  status_sel = dtrf_pkg::STS_INVALID;
               end else if (rec_rd.boot == boot_ff && rec_rd.newest != 32'd0 && not_newer) begin
                  status_sel = dtrf_pkg::STS_REPLAY;
               end else begin
                  rec_we              = 1'b1;
                  rec_wdata.boot      = boot_ff;
                  rec_wdata.newest    = seq_ff;
                  rec_wdata.last_seen = time_ff;
                  rec_wdata.online    = 1'b1;
               end
            end
            dtrf_pkg::ACT_AVAIL: begin
               rec_we              = 1'b1;
               rec_wdata.boot      = rec_rd.boot;
               rec_wdata.newest    = rec_rd.newest;
               rec_wdata.last_seen = time_ff;
               rec_wdata.online    = online_ff;
            end
            default: begin
               status_sel = dtrf_pkg::STS_OK;
            end
         endcase
      end
   end

   // table occupancy update
   always_comb begin
      used_in  = used_ff;
      total_in = total_ff;
      if (exec_fire && used_set) begin
         used_in[wr_idx] = 1'b1;
         total_in        = total_ff + CNT_ONE;
      end else if (exec_fire && used_clr) begin
         used_in[wr_idx] = 1'b0;
         if (total_ff != '0) begin
            total_in = total_ff - CNT_ONE;
         end
      end
   end

   // low bits of slot and count go out
   assign slot_wide  = {4'b0000, (slot_none ? {IDX_W{1'b0}} : wr_idx)};
   assign total_wide = {5'b00000, total_in};

   // result register, free once its beat is taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_total_in  = rsp_total_ff;
      if (exec_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_sel;
         rsp_slot_in   = slot_wide[3:0];
         rsp_total_in  = total_wide[4:0];
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= dtrf_pkg::FSM_IDLE;
         used_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         used_ff      <= used_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_total_ff  <= rsp_total_in;
      // request beat captured on acceptance, key trimmed to its byte count
      if (req_take) begin
         act_ff    <= dtrf_pkg::action_type'(req_action);
         key_ff    <= req_node_key[KEY_W-1:0];
         boot_ff   <= req_boot_id;
         seq_ff    <= req_sequence_req;
         time_ff   <= req_time_ms;
         online_ff <= req_online;
      end
   end

   dtrf_lookup #(
      .DEVICE_SLOTS (DEVICE_SLOTS),
      .KEY_W        (KEY_W)
   ) u_lookup (
      .clock       (clock),
      .reset       (reset),
      .start       (scan_start),
      .key         (key_ff),
      .used        (used_ff),
      .key_rd_addr (key_rd_addr),
      .key_rd_data (key_rd_data),
      .result      (scan_res),
      .hit_idx     (hit_idx),
      .free_idx    (free_idx)
   );

   // slot keys, only ever compared for slots in use
   dtrf_ram #(
      .WIDTH (KEY_W),
      .DEPTH (DEVICE_SLOTS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (exec_fire && key_we),
      .wr_addr (wr_idx),
      .wr_data (key_ff),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   // slot records: boot id, newest sequence, last seen, online
   dtrf_ram #(
      .WIDTH (REC_W),
      .DEPTH (DEVICE_SLOTS)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (exec_fire && rec_we),
      .wr_addr (wr_idx),
      .wr_data (rec_wdata),
      .rd_addr (hit_idx),
      .rd_data (rec_rd_bits)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_device_total = rsp_total_ff;

endmodule

/* test/testbench.sv */
// self-checking testbench for the device table replay filter unit
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = 16;
   localparam int ROWS        = 25;
   localparam int PHASES      = 5;
   localparam int PHASE_BEATS = 108;
   localparam int HOLD_CYCLES = 300;
   localparam int QUIET_LIMIT = 2000;
   localparam int TAIL_CYCLES = 50;
   localparam logic [63:0] KEY_TOP = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [31:0] WORD_TOP = 32'hFFFF_FFFF;

   // one request beat, field for field as the ports carry it
   typedef struct packed {
      dtrf_pkg::action_type act;
      logic [63:0]          key;
      logic [31:0]          boot;
      logic [31:0]          seq;
      logic [63:0]          stamp;
      logic                 on;
   } request_beat_type;

   // one result beat
   typedef struct packed {
      dtrf_pkg::status_type status;
      logic [3:0]           slot;
      logic [4:0]           total;
   } slot_answer_type;

   // directed row: the answer is only used when typed is set
   typedef struct packed {
      request_beat_type beat;
      logic             typed;
      slot_answer_type  answer;
   } script_row_type;

   // directed stimulus; typed answers are the ones obvious from the spec,
   // the wrap-around and boot change rows go through the predictor
   localparam script_row_type SCRIPT [ROWS] = '{
      // lookups on an empty table
      '{'{dtrf_pkg::ACT_MESSAGE,  64'h0,   32'd1, 32'd1, 64'h0, 1'b0}, 1'b1,
        '{dtrf_pkg::STS_NOT_FOUND, 4'd0, 5'd0}},
      '{'{dtrf_pkg::ACT_RELEASE,  KEY_TOP, 32'd0, 32'd0, 64'h0, 1'b0}, 1'b1,
        '{dtrf_pkg::STS_NOT_FOUND, 4'd0, 5'd0}},
      '{'{dtrf_pkg::ACT_AVAIL,    64'h0,   32'd0, 32'd0, KEY_TOP, 1'b1}, 1'b1,
        '{dtrf_pkg::STS_NOT_FOUND, 4'd0, 5'd0}},
      // extreme keys, then a register of a key already present
      '{'{dtrf_pkg::ACT_REGISTER, 64'h0,   32'd0, 32'd0, 64'h0, 1'b0}, 1'b1,
        '{dtrf_pkg::STS_OK, 4'd0, 5'd1}},
      '{'{dtrf_pkg::ACT_REGISTER, KEY_TOP, WORD_TOP, WORD_TOP, KEY_TOP, 1'b1}, 1'b1,
        '{dtrf_pkg::STS_OK, 4'd1, 5'd2}},
      '{'{dtrf_pkg::ACT_REGISTER, 64'h0,   32'd7, 32'd7, 64'h7, 1'b1}, 1'b1,
        '{dtrf_pkg::STS_OK, 4'd0, 5'd2}},
      // zero boot id, zero sequence
      '{'{dtrf_pkg::ACT_MESSAGE,  64'h0,   32'd0, 32'd5, 64'h0, 1'b0}, 1'b1,
        '{dtrf_pkg::STS_INVALID, 4'd0, 5'd2}},
      '{'{dtrf_pkg::ACT_MESSAGE,  64'h0,   32'd1, 32'd0, 64'h0, 1'b0}, 1'b1,
        '{dtrf_pkg::STS_INVALID, 4'd0, 5'd2}},
      // first message, straight repeat, half-range jump back
      '{'{dtrf_pkg::ACT_MESSAGE,  64'h0,   32'd1, 32'd1, 64'h1234, 1'b0}, 1'b1,
        '{dtrf_pkg::STS_OK, 4'd0, 5'd2}},
      '{'{dtrf_pkg::ACT_MESSAGE,  64'h0,   32'd1, 32'd1, 64'h1235, 1'b0}, 1'b1,
        '{dtrf_pkg::STS_REPLAY, 4'd0, 5'd2}},
      '{'{dtrf_pkg::ACT_MESSAGE,  64'h0,   32'd1, 32'h8000_0001, 64'h9, 1'b0}, 1'b1,
        '{dtrf_pkg::STS_REPLAY, 4'd0, 5'd2}},
      // largest forward step, wrap past the top, new boot id
      '{'{dtrf_pkg::ACT_MESSAGE,  64'h0,   32'd1, 32'h8000_0000, 64'hA, 1'b0}, 1'b0,
        '{dtrf_pkg::STS_OK, 4'd0, 5'd0}},
      '{'{dtrf_pkg::ACT_MESSAGE,  64'h0,   32'd1, WORD_TOP, 64'hB, 1'b0}, 1'b0,
        '{dtrf_pkg::STS_OK, 4'd0, 5'd0}},
      '{'{dtrf_pkg::ACT_MESSAGE,  64'h0,   32'd1, 32'd1, 64'hC, 1'b0}, 1'b0,
        '{dtrf_pkg::STS_OK, 4'd0, 5'd0}},
      '{'{dtrf_pkg::ACT_MESSAGE,  64'h0,   WORD_TOP, 32'd1, 64'hD, 1'b0}, 1'b0,
        '{dtrf_pkg::STS_OK, 4'd0, 5'd0}},
      '{'{dtrf_pkg::ACT_MESSAGE,  KEY_TOP, WORD_TOP, WORD_TOP, KEY_TOP, 1'b1}, 1'b0,
        '{dtrf_pkg::STS_OK, 4'd0, 5'd0}},
      // availability both ways
      '{'{dtrf_pkg::ACT_AVAIL,    KEY_TOP, 32'd0, 32'd0, 64'h0, 1'b0}, 1'b0,
        '{dtrf_pkg::STS_OK, 4'd0, 5'd0}},
      '{'{dtrf_pkg::ACT_AVAIL,    64'h0,   32'd0, 32'd0, KEY_TOP, 1'b1}, 1'b0,
        '{dtrf_pkg::STS_OK, 4'd0, 5'd0}},
      // release, then the slot is gone and the lowest free slot is reused
      '{'{dtrf_pkg::ACT_RELEASE,  64'h0,   32'd0, 32'd0, 64'h0, 1'b0}, 1'b1,
        '{dtrf_pkg::STS_OK, 4'd0, 5'd1}},
      '{'{dtrf_pkg::ACT_MESSAGE,  64'h0,   32'd1, 32'd2, 64'h0, 1'b0}, 1'b1,
        '{dtrf_pkg::STS_NOT_FOUND, 4'd0, 5'd1}},
      '{'{dtrf_pkg::ACT_REGISTER, 64'h5,   32'd0, 32'd0, 64'h0, 1'b0}, 1'b1,
        '{dtrf_pkg::STS_OK, 4'd0, 5'd2}},
      '{'{dtrf_pkg::ACT_MESSAGE,  64'h5,   32'd1, 32'd1, 64'h55, 1'b1}, 1'b0,
        '{dtrf_pkg::STS_OK, 4'd0, 5'd0}},
      '{'{dtrf_pkg::ACT_REGISTER, KEY_TOP, 32'd0, 32'd0, 64'h0, 1'b0}, 1'b1,
        '{dtrf_pkg::STS_OK, 4'd1, 5'd2}},
      '{'{dtrf_pkg::ACT_RELEASE,  KEY_TOP, 32'd0, 32'd0, 64'h0, 1'b0}, 1'b1,
        '{dtrf_pkg::STS_OK, 4'd1, 5'd1}},
      '{'{dtrf_pkg::ACT_AVAIL,    KEY_TOP, 32'd0, 32'd0, 64'h1, 1'b1}, 1'b1,
        '{dtrf_pkg::STS_NOT_FOUND, 4'd0, 5'd1}}
   };

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [63:0] req_node_key;
   logic [31:0] req_boot_id;
   logic [31:0] req_sequence_req;
   logic [63:0] req_time_ms;
   logic        req_online;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_slot;
   logic [4:0]  rsp_device_total;

   // predicted copy of the slot table
   logic        slot_taken   [SLOTS];
   logic [63:0] slot_node    [SLOTS];
   logic [31:0] slot_boot_id [SLOTS];
   logic [31:0] slot_top_seq [SLOTS];
   logic [63:0] slot_seen_ms [SLOTS];
   logic        slot_live    [SLOTS];
   int unsigned occupied;

   slot_answer_type answers_due [$]; // results still owed by the block, oldest first
   logic [63:0] key_pool [24];       // keys the random part draws from
   int          mismatches   = 0;
   int          quiet_cycles = 0;
   int          burst_left   = 0;
   int          stall_mode   = 0;
   int          stall_span   = 0;
   bit          hold_request = 1'b0;

   device_table_replay_filter_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_action       (req_action),
      .req_node_key     (req_node_key),
      .req_boot_id      (req_boot_id),
      .req_sequence_req (req_sequence_req),
      .req_time_ms      (req_time_ms),
      .req_online       (req_online),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_device_total (rsp_device_total)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int lookup_slot(input logic [63:0] key);
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_taken[i] && slot_node[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic void wipe_slot(input int i);
      slot_taken[i]   = 1'b0;
      slot_boot_id[i] = '0;
      slot_top_seq[i] = '0;
      slot_seen_ms[i] = '0;
      slot_live[i]    = 1'b0;
   endfunction

   // applies one request to the predicted table and returns its result
   function automatic slot_answer_type apply_action(input request_beat_type b);
      slot_answer_type a;
      int              hit;
      int              spare;
      logic [31:0]     step;
      a.status = dtrf_pkg::STS_OK;
      a.slot   = '0;
      hit      = lookup_slot(b.key);
      if (b.act == dtrf_pkg::ACT_REGISTER) begin
         if (hit >= 0) begin
            // already known: hand back the existing slot, nothing changes
            a.slot = hit[3:0];
         end else begin
            spare = -1;
            if (occupied < SLOTS) begin
               for (int i = 0; i < SLOTS; i++) begin
                  if (!slot_taken[i] && spare < 0) spare = i;
               end
            end
            if (spare < 0) begin
               a.status = dtrf_pkg::STS_FULL;
            end else begin
               wipe_slot(spare);
               slot_taken[spare] = 1'b1;
               slot_node[spare]  = b.key;
               occupied++;
               a.slot = spare[3:0];
            end
         end
      end else if (hit < 0) begin
         a.status = dtrf_pkg::STS_NOT_FOUND;
      end else begin
         a.slot = hit[3:0];
         case (b.act)
            dtrf_pkg::ACT_RELEASE: begin
               wipe_slot(hit);
               if (occupied > 0) occupied--;
            end
            dtrf_pkg::ACT_MESSAGE: begin
               step = b.seq - slot_top_seq[hit];
               if (b.boot == '0 || b.seq == '0) begin
                  a.status = dtrf_pkg::STS_INVALID;
               end else if (slot_boot_id[hit] == b.boot && slot_top_seq[hit] != '0 &&
                            (step == '0 || step[31])) begin
                  // same boot and not newer in wrap-around order
                  a.status = dtrf_pkg::STS_REPLAY;
               end else begin
                  slot_boot_id[hit] = b.boot;
                  slot_top_seq[hit] = b.seq;
                  slot_seen_ms[hit] = b.stamp;
                  slot_live[hit]    = 1'b1;
               end
            end
            default: begin
               slot_live[hit]    = b.on;
               slot_seen_ms[hit] = b.stamp;
            end
         endcase
      end
      a.total = occupied[4:0];
      return a;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic void refill_pool(input int n);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 9))
            0:       key_pool[i] = '0;
            1:       key_pool[i] = KEY_TOP;
            default: key_pool[i] = {$urandom, $urandom};
         endcase
      end
   endfunction

   // random request; messages to known keys mostly follow the stored
   // sequence so that the replay window is exercised from both sides
   function automatic request_beat_type make_beat(input int pool_n, input int reg_pct,
                                                  input int rel_pct, input int msg_pct);
      request_beat_type b;
      int               pick;
      int               hit;
      logic [31:0]      base;
      b.key   = ($urandom_range(0, 99) < 92) ? key_pool[$urandom_range(0, pool_n - 1)]
                                             : {$urandom, $urandom};
      b.boot  = $urandom;
      b.seq   = $urandom;
      b.stamp = {$urandom, $urandom};
      b.on    = 1'($urandom_range(0, 1));
      pick    = $urandom_range(0, 99);
      if (pick < reg_pct) b.act = dtrf_pkg::ACT_REGISTER;
      else if (pick < reg_pct + rel_pct) b.act = dtrf_pkg::ACT_RELEASE;
      else if (pick < reg_pct + rel_pct + msg_pct) b.act = dtrf_pkg::ACT_MESSAGE;
      else b.act = dtrf_pkg::ACT_AVAIL;
      hit = lookup_slot(b.key);
      if (b.act == dtrf_pkg::ACT_MESSAGE && hit >= 0) begin
         base = slot_top_seq[hit];
         if (slot_boot_id[hit] != '0) b.boot = slot_boot_id[hit];
         pick = $urandom_range(0, 99);
         if (pick < 60) b.seq = base + 32'($urandom_range(1, 5));
         else if (pick < 78) b.seq = base - 32'($urandom_range(0, 4));
         else if (pick < 86) b.seq = base + 32'h8000_0000 - 32'($urandom_range(0, 1));
         else if (pick < 92) b.boot = $urandom;
         else if (pick < 96) b.boot = '0;
         else b.seq = '0;
      end
      return b;
   endfunction

   task automatic report(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   // offer one beat from a falling edge and hold it until taken; the
   // prediction is made at the accepting edge, then back to a falling edge
   task automatic offer(input request_beat_type b, input logic typed,
                        input slot_answer_type want);
      slot_answer_type got;
      req_valid        <= 1'b1;
      req_action       <= b.act;
      req_node_key     <= b.key;
      req_boot_id      <= b.boot;
      req_sequence_req <= b.seq;
      req_time_ms      <= b.stamp;
      req_online       <= b.on;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = apply_action(b);
      answers_due.push_back(typed ? want : got);
      @(negedge clock);
   endtask

   // sender bursts: after a burst, drop valid for a random gap
   task automatic pace();
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
   endtask

   // sender pause until the block has answered everything
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------- main sequence

   initial begin
      request_beat_type b;
      slot_answer_type  none;
      int               pool_n;
      int               reg_pct;
      int               rel_pct;
      int               msg_pct;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_action       = dtrf_pkg::ACT_REGISTER;
      req_node_key     = '0;
      req_boot_id      = '0;
      req_sequence_req = '0;
      req_time_ms      = '0;
      req_online       = 1'b0;
      none             = '{dtrf_pkg::STS_OK, 4'd0, 5'd0};
      for (int i = 0; i < SLOTS; i++) begin
         wipe_slot(i);
         slot_node[i] = '0;
      end
      occupied = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed rows
      for (int r = 0; r < ROWS; r++) begin
         pace();
         offer(SCRIPT[r].beat, SCRIPT[r].typed, SCRIPT[r].answer);
      end
      wait_drained();

      // random phases: each has its own key pool size and action mix;
      //   the first is register-heavy on a pool larger than the table so the table fills
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       begin pool_n = 20; reg_pct = 55; rel_pct = 3;  msg_pct = 30; end
            1:       begin pool_n = 8;  reg_pct = 25; rel_pct = 10; msg_pct = 45; end
            2:       begin pool_n = 24; reg_pct = 20; rel_pct = 12; msg_pct = 50; end
            3:       begin pool_n = 12; reg_pct = 30; rel_pct = 8;  msg_pct = 42; end
            default: begin pool_n = 18; reg_pct = 35; rel_pct = 15; msg_pct = 30; end
         endcase
         refill_pool(pool_n);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            // long receiver hold-off while requests keep coming
            if (phase == 1 && n == 30) hold_request = 1'b1;
            if (phase == 3 && n == 0) wait_drained();
            else pace();
            b = make_beat(pool_n, reg_pct, rel_pct, msg_pct);
            offer(b, 1'b0, none);
         end
      end

      // let everything come back, then a quiet tail for stray beats
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // ---------------------------------------------------------------- receiver

   // stall pattern changes mode after a random span: open, sparse,
   // alternating, mostly closed; a hold request closes it for a long stretch
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            hold_request = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (stall_span == 0) begin
               stall_mode = $urandom_range(0, 3);
               stall_span = $urandom_range(8, 80);
            end
            stall_span--;
            case (stall_mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 99) < 30);
               2:       rsp_stall <= ~rsp_stall;
               default: rsp_stall <= ($urandom_range(0, 99) < 80);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------- checker

   always @(posedge clock) begin
      slot_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_due.size() == 0) begin
            report("result beat with nothing outstanding");
         end else begin
            want = answers_due.pop_front();
            if (rsp_status !== want.status)
               report($sformatf("status got %0d want %0d", rsp_status, want.status));
            if (rsp_slot !== want.slot)
               report($sformatf("slot got %0d want %0d", rsp_slot, want.slot));
            if (rsp_device_total !== want.total)
               report($sformatf("device_total got %0d want %0d", rsp_device_total,
                                want.total));
         end
      end
   end

   // watchdog: too long with no beat on either channel ends the run
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

endmodule
